// File: hw/rtl/cdll_pkg.sv
`timescale 1ns / 1ps
// Shared types, codes and widths of the circular doubly linked list manager.
package cdll_pkg;

    localparam int ACTION_W = 3;
    localparam int NODE_W = 8;
    localparam int STATUS_W = 2;
    localparam int COUNT_W = 9;

    localparam int IN_TDATA_W = 16;
    localparam int OUT_TDATA_W = 24;

    localparam int DEF_POOL_NODES = 256;

    localparam logic [ACTION_W-1:0] ACT_APPEND = 3'd0;
    localparam logic [ACTION_W-1:0] ACT_PUSH = 3'd1;
    localparam logic [ACTION_W-1:0] ACT_POP_HEAD = 3'd2;
    localparam logic [ACTION_W-1:0] ACT_POP_TAIL = 3'd3;
    localparam logic [ACTION_W-1:0] ACT_UNLINK = 3'd4;
    localparam logic [ACTION_W-1:0] ACT_ROTATE = 3'd5;

    localparam logic [STATUS_W-1:0] ST_OK = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL = 2'd2;

    // Packed from the top down so that removed_node lands in the lowest bits.
    typedef struct packed {
        logic [COUNT_W-1:0]  node_count;
        logic                list_empty;
        logic [STATUS_W-1:0] status;
        logic [NODE_W-1:0]   removed_node;
    } result_t;

endpackage

// File: hw/rtl/cdll_ram.sv
`timescale 1ns / 1ps
// Generic single-clock RAM: one write port, one read port, registered read data.
module cdll_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// File: hw/rtl/cdll_out_stage.sv
`timescale 1ns / 1ps
// Output register of the result stream: holds one result until the sink takes it.
module cdll_out_stage (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                load,
    input  cdll_pkg::result_t                   res,
    output logic                                free,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [cdll_pkg::OUT_TDATA_W-1:0]    m_axis_tdata
);

    logic              valid_reg;
    logic              valid_next;
    cdll_pkg::result_t data_reg;

    // Slot is free when empty or when the waiting result leaves this cycle.
    assign free = !valid_reg || m_axis_tready;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= res;
        end
    end

    assign m_axis_tvalid = valid_reg;
    assign m_axis_tdata = cdll_pkg::OUT_TDATA_W'(data_reg);

endmodule

// File: hw/rtl/circular_doubly_linked_list_manager.sv
`timescale 1ns / 1ps
// Top level of the circular doubly linked list manager.
//
// Use: commands arrive on the s_axis stream, one transaction per command
// (action in tdata[2:0], node index in tdata[10:3]); every command gives
// exactly one result transaction on m_axis (removed node, status, empty
// flag, node count). The list lives in two link RAMs (next with a member
// flag, prev) plus head, tail and count registers.
// Flow: commands are handled one at a time. A command whose outcome is
// known from the registers (empty list, unused code) goes straight to
// S_DONE; rotate, refused inserts, inserts into an empty list and
// removals of the last node pass through S_EVAL; inserts into a non-empty
// list and removals of an inner node add S_WR2, set by the single
// write port of the next-link RAM (two writes per command) after a read.
// Reset: head, tail and count clear at once, then a clearing pass walks
// every entry of the next-link RAM to drop its member flag; s_axis_tready
// stays low during the pass.
// Stall: a finished result waits in the output register; the next command
// is accepted and processed meanwhile and holds in its final state until
// the register frees up.
module circular_doubly_linked_list_manager #(
    parameter int POOL_NODES = cdll_pkg::DEF_POOL_NODES
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // tdata: [2:0] action, [10:3] node_index, [15:11] zero
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [cdll_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    // tdata: [7:0] removed_node, [9:8] status, [10] list_empty,
    //        [19:11] node_count, [23:20] zero
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [cdll_pkg::OUT_TDATA_W-1:0]    m_axis_tdata
);

    localparam int IDX_W = $clog2(POOL_NODES);
    localparam int CNT_W = $clog2(POOL_NODES + 1);
    localparam int NXT_W = IDX_W + 1;

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE = 3'd1;
    localparam logic [2:0] S_EVAL = 3'd2;
    localparam logic [2:0] S_WR2 = 3'd3;
    localparam logic [2:0] S_DONE = 3'd4;

    // Build the index folding table: every 8-bit index modulo the pool size.
    function automatic logic [255:0][IDX_W-1:0] fold_table();
        logic [255:0][IDX_W-1:0] t;
        for (int v = 0; v < 256; v++)
        begin
            t[8'(v)] = IDX_W'(v % POOL_NODES);
        end
        return t;
    endfunction

    localparam logic [255:0][IDX_W-1:0] FOLD_TAB = fold_table();

    logic [2:0]                      state_reg, state_next;
    logic [IDX_W-1:0]                clr_idx_reg, clr_idx_next;
    logic [cdll_pkg::ACTION_W-1:0]   act_reg, act_next;
    logic [IDX_W-1:0]                node_reg, node_next;
    logic [IDX_W-1:0]                head_reg, head_next;
    logic [IDX_W-1:0]                tail_reg, tail_next;
    logic [CNT_W-1:0]                count_reg, count_next;
    logic [IDX_W-1:0]                removed_reg, removed_next;
    logic [cdll_pkg::STATUS_W-1:0]   status_reg, status_next;

    // Link RAM ports: next RAM word is {member, next}, prev RAM word is prev.
    logic             nxt_we;
    logic [IDX_W-1:0] nxt_waddr;
    logic [NXT_W-1:0] nxt_wdata;
    logic [NXT_W-1:0] nxt_rdata;
    logic             prv_we;
    logic [IDX_W-1:0] prv_waddr;
    logic [IDX_W-1:0] prv_wdata;
    logic [IDX_W-1:0] prv_rdata;
    logic [IDX_W-1:0] rd_addr;

    logic                          in_fire;
    logic [cdll_pkg::ACTION_W-1:0] in_action;
    logic [IDX_W-1:0]              in_node;
    logic                          rd_member;
    logic [IDX_W-1:0]              rd_after;
    logic                          list_none;
    logic                          list_full;

    logic              out_load;
    logic              out_free;
    cdll_pkg::result_t res;

    assign s_axis_tready = (state_reg == S_IDLE);
    assign in_fire = s_axis_tvalid && s_axis_tready;
    assign in_action = s_axis_tdata[2:0];
    assign in_node = FOLD_TAB[s_axis_tdata[10:3]];

    assign rd_member = nxt_rdata[IDX_W];
    assign rd_after = nxt_rdata[IDX_W-1:0];
    assign list_none = (count_reg == '0);
    assign list_full = (count_reg == CNT_W'(POOL_NODES));

    always_comb
    begin
        state_next = state_reg;
        clr_idx_next = clr_idx_reg;
        act_next = act_reg;
        node_next = node_reg;
        head_next = head_reg;
        tail_next = tail_reg;
        count_next = count_reg;
        removed_next = removed_reg;
        status_next = status_reg;
        rd_addr = in_node;
        nxt_we = 1'b0;
        nxt_waddr = node_reg;
        nxt_wdata = {1'b0, node_reg};
        prv_we = 1'b0;
        prv_waddr = node_reg;
        prv_wdata = node_reg;
        out_load = 1'b0;

        case (state_reg)
            S_CLEAR:
            begin
                // Drop the member flag of one entry per cycle.
                nxt_we = 1'b1;
                nxt_waddr = clr_idx_reg;
                nxt_wdata = {1'b0, clr_idx_reg};
                clr_idx_next = clr_idx_reg + 1'b1;
                if (clr_idx_reg == IDX_W'(POOL_NODES - 1))
                begin
                    state_next = S_IDLE;
                end
            end

            S_IDLE:
            begin
                if (in_fire)
                begin
                    act_next = in_action;
                    node_next = in_node;
                    removed_next = '0;
                    status_next = cdll_pkg::ST_OK;
                    state_next = S_EVAL;
                    case (in_action)
                        cdll_pkg::ACT_APPEND, cdll_pkg::ACT_PUSH,
                        cdll_pkg::ACT_UNLINK:
                        begin
                            rd_addr = in_node;
                        end
                        cdll_pkg::ACT_POP_HEAD, cdll_pkg::ACT_ROTATE:
                        begin
                            rd_addr = head_reg;
                            node_next = head_reg;
                        end
                        cdll_pkg::ACT_POP_TAIL:
                        begin
                            rd_addr = tail_reg;
                            node_next = tail_reg;
                        end
                        default:
                        begin
                            // Unused code: nothing changes.
                            state_next = S_DONE;
                        end
                    endcase
                    if (list_none && in_action inside {cdll_pkg::ACT_POP_HEAD,
                        cdll_pkg::ACT_POP_TAIL, cdll_pkg::ACT_UNLINK,
                        cdll_pkg::ACT_ROTATE})
                    begin
                        status_next = cdll_pkg::ST_EMPTY;
                        state_next = S_DONE;
                    end
                end
            end

            S_EVAL:
            begin
                state_next = S_DONE;
                case (act_reg)
                    cdll_pkg::ACT_APPEND, cdll_pkg::ACT_PUSH:
                    begin
                        if (list_full || rd_member)
                        begin
                            status_next = cdll_pkg::ST_FULL;
                        end
                        else if (list_none)
                        begin
                            // First node links to itself both ways.
                            nxt_we = 1'b1;
                            nxt_wdata = {1'b1, node_reg};
                            prv_we = 1'b1;
                            prv_wdata = node_reg;
                            head_next = node_reg;
                            tail_next = node_reg;
                            count_next = CNT_W'(1);
                        end
                        else
                        begin
                            // New node sits between tail and head.
                            nxt_we = 1'b1;
                            nxt_wdata = {1'b1, head_reg};
                            prv_we = 1'b1;
                            prv_wdata = tail_reg;
                            state_next = S_WR2;
                        end
                    end

                    cdll_pkg::ACT_POP_HEAD, cdll_pkg::ACT_POP_TAIL,
                    cdll_pkg::ACT_UNLINK:
                    begin
                        if (!rd_member)
                        begin
                            status_next = cdll_pkg::ST_EMPTY;
                        end
                        else if (count_reg == CNT_W'(1))
                        begin
                            // Last node leaves: list returns to its reset shape.
                            nxt_we = 1'b1;
                            nxt_wdata = {1'b0, node_reg};
                            head_next = '0;
                            tail_next = '0;
                            count_next = '0;
                            removed_next = node_reg;
                        end
                        else
                        begin
                            // Bridge the neighbours, then clear the member flag.
                            nxt_we = 1'b1;
                            nxt_waddr = prv_rdata;
                            nxt_wdata = {1'b1, rd_after};
                            prv_we = 1'b1;
                            prv_waddr = rd_after;
                            prv_wdata = prv_rdata;
                            if (node_reg == head_reg)
                            begin
                                head_next = rd_after;
                            end
                            if (node_reg == tail_reg)
                            begin
                                tail_next = prv_rdata;
                            end
                            count_next = count_reg - 1'b1;
                            removed_next = node_reg;
                            state_next = S_WR2;
                        end
                    end

                    cdll_pkg::ACT_ROTATE:
                    begin
                        tail_next = head_reg;
                        head_next = rd_after;
                    end

                    default:
                    begin
                        state_next = S_DONE;
                    end
                endcase
            end

            S_WR2:
            begin
                state_next = S_DONE;
                if (act_reg inside {cdll_pkg::ACT_APPEND, cdll_pkg::ACT_PUSH})
                begin
                    nxt_we = 1'b1;
                    nxt_waddr = tail_reg;
                    nxt_wdata = {1'b1, node_reg};
                    prv_we = 1'b1;
                    prv_waddr = head_reg;
                    prv_wdata = node_reg;
                    if (act_reg == cdll_pkg::ACT_PUSH)
                    begin
                        head_next = node_reg;
                    end
                    else
                    begin
                        tail_next = node_reg;
                    end
                    count_next = count_reg + 1'b1;
                end
                else
                begin
                    nxt_we = 1'b1;
                    nxt_wdata = {1'b0, node_reg};
                end
            end

            S_DONE:
            begin
                // Hold until the output register can take the result.
                if (out_free)
                begin
                    out_load = 1'b1;
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            clr_idx_reg <= '0;
            head_reg <= '0;
            tail_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            clr_idx_reg <= clr_idx_next;
            head_reg <= head_next;
            tail_reg <= tail_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        act_reg <= act_next;
        node_reg <= node_next;
        removed_reg <= removed_next;
        status_reg <= status_next;
    end

    cdll_ram #(
        .WIDTH (NXT_W),
        .DEPTH (POOL_NODES)
    ) u_next_ram (
        .clk   (clk),
        .we    (nxt_we),
        .waddr (nxt_waddr),
        .wdata (nxt_wdata),
        .raddr (rd_addr),
        .rdata (nxt_rdata)
    );

    cdll_ram #(
        .WIDTH (IDX_W),
        .DEPTH (POOL_NODES)
    ) u_prev_ram (
        .clk   (clk),
        .we    (prv_we),
        .waddr (prv_waddr),
        .wdata (prv_wdata),
        .raddr (rd_addr),
        .rdata (prv_rdata)
    );

    // Count and empty flag are taken after the command has taken effect.
    assign res.removed_node = cdll_pkg::NODE_W'(removed_reg);
    assign res.status = status_reg;
    assign res.list_empty = list_none;
    assign res.node_count = cdll_pkg::COUNT_W'(count_reg);

    cdll_out_stage u_out_stage (
        .clk           (clk),
        .rst_n         (rst_n),
        .load          (out_load),
        .res           (res),
        .free          (out_free),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

endmodule

// File: hw/rtl/cdll_checker.sv
`timescale 1ns / 1ps
// Port-level checker of the circular doubly linked list manager, with its bind.
module cdll_checker (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             s_axis_tvalid,
    input logic                             s_axis_tready,
    input logic                             m_axis_tvalid,
    input logic                             m_axis_tready,
    input logic [cdll_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);

    // A stalled result holds.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

    // One command at a time: busy in the cycle after a command is taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("command taken while the previous one is in flight");

    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[9:8] == cdll_pkg::ST_OK
            || m_axis_tdata[9:8] == cdll_pkg::ST_EMPTY
            || m_axis_tdata[9:8] == cdll_pkg::ST_FULL)
    else $error("status code out of range");

    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[10] == (m_axis_tdata[19:11] == '0))
    else $error("empty flag disagrees with node count");

    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[9:8] != cdll_pkg::ST_OK
            |-> m_axis_tdata[7:0] == '0)
    else $error("removed node reported on a failed command");

endmodule

bind circular_doubly_linked_list_manager cdll_checker u_cdll_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

// File: bench/tb_top.sv
`timescale 1ns / 1ps
// Self-checking bench for the circular doubly linked list manager.
module tb_top;
    import cdll_pkg::*;

    localparam int POOL = DEF_POOL_NODES;
    // Unused action codes; the block must treat them as no-ops.
    localparam logic [ACTION_W-1:0] ACT_SPARE_LO = 3'd6;
    localparam logic [ACTION_W-1:0] ACT_SPARE_HI = 3'd7;
    // Generous bound: ~2200 commands, stalls on both sides, the receiver
    // hold-off and the clearing pass after reset, many times over.
    localparam int CYCLE_LIMIT = 400000;
    localparam int HOLD_CYCLES = 400;
    localparam int TAIL_CYCLES = 20;
    localparam int MAX_REPORTS = 10;

    typedef struct {
        logic [ACTION_W-1:0] act;
        logic [NODE_W-1:0]   node;
        bit                  typed;
        result_t             want;
    } stim_row_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;

    // Shadow copy of the list, advanced at every accepted command transaction.
    int link_fwd [POOL];
    int link_bwd [POOL];
    bit in_list [POOL];
    int list_head = 0;
    int list_tail = 0;
    int list_len = 0;

    result_t pending_results [$];
    int      n_bad = 0;
    int      cycles = 0;

    // Idle rates in percent, set per phase by the stimulus process.
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    // Hold-off requests: the stimulus bumps hold_reqs, the receiver acts on it.
    int hold_reqs = 0;
    int hold_seen = 0;
    int hold_left = 0;

    circular_doubly_linked_list_manager dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Abort the run if the block hangs.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    // Receiver: random stalls, or a long hold-off counted down here.
    always @(posedge clk)
    begin
        if (hold_seen != hold_reqs)
        begin
            hold_seen     <= hold_reqs;
            hold_left     <= HOLD_CYCLES;
            m_axis_tready <= 1'b0;
        end
        else if (hold_left != 0)
        begin
            hold_left     <= hold_left - 1;
            m_axis_tready <= 1'b0;
        end
        else
        begin
            m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Compare every result transaction with the oldest expected result.
    always @(posedge clk)
    begin
        result_t got;
        result_t w;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got = m_axis_tdata[$bits(result_t)-1:0];
            if (pending_results.size() == 0)
            begin
                n_bad++;
                if (n_bad <= MAX_REPORTS)
                    $display("unexpected result: node %0d status %0d empty %0d count %0d",
                             got.removed_node, got.status, got.list_empty, got.node_count);
            end
            else
            begin
                w = pending_results.pop_front();
                if (got.removed_node !== w.removed_node || got.status !== w.status ||
                    got.list_empty !== w.list_empty || got.node_count !== w.node_count)
                begin
                    n_bad++;
                    if (n_bad <= MAX_REPORTS)
                        $display("mismatch: node %0d/%0d status %0d/%0d empty %0d/%0d count %0d/%0d (exp/act)",
                                 w.removed_node, got.removed_node, w.status, got.status,
                                 w.list_empty, got.list_empty, w.node_count, got.node_count);
                end
            end
        end
    end

    function automatic result_t make_result(input int removed, input logic [STATUS_W-1:0] st,
                                            input bit empty, input int len);
        result_t r;
        r.removed_node = NODE_W'(removed);
        r.status       = st;
        r.list_empty   = empty;
        r.node_count   = COUNT_W'(len);
        return r;
    endfunction

    // Unhook a member node from the shadow list.
    function automatic void drop_node(input int n);
        int prv;
        int nxt;
        if (list_len <= 1)
        begin
            list_head = 0;
            list_tail = 0;
            list_len  = 0;
        end
        else
        begin
            prv = link_bwd[n];
            nxt = link_fwd[n];
            link_fwd[prv] = nxt;
            link_bwd[nxt] = prv;
            if (n == list_head)
                list_head = nxt;
            if (n == list_tail)
                list_tail = prv;
            list_len--;
        end
        in_list[n] = 1'b0;
    endfunction

    // Apply one command to the shadow list and return the result it should give.
    function automatic result_t apply_cmd(input logic [ACTION_W-1:0] act,
                                          input logic [NODE_W-1:0] node);
        logic [STATUS_W-1:0] st;
        int n;
        int removed;
        int victim;
        n       = int'(node) % POOL;
        st      = ST_OK;
        removed = 0;
        case (act)
            ACT_APPEND, ACT_PUSH:
            begin
                if (list_len >= POOL || in_list[n])
                    st = ST_FULL;
                else
                begin
                    if (list_len == 0)
                    begin
                        list_head   = n;
                        list_tail   = n;
                        link_fwd[n] = n;
                        link_bwd[n] = n;
                    end
                    else
                    begin
                        link_fwd[n]         = list_head;
                        link_bwd[n]         = list_tail;
                        link_fwd[list_tail] = n;
                        link_bwd[list_head] = n;
                        if (act == ACT_PUSH)
                            list_head = n;
                        else
                            list_tail = n;
                    end
                    in_list[n] = 1'b1;
                    list_len++;
                end
            end
            ACT_POP_HEAD, ACT_POP_TAIL:
            begin
                if (list_len == 0)
                    st = ST_EMPTY;
                else
                begin
                    victim = (act == ACT_POP_HEAD) ? list_head : list_tail;
                    drop_node(victim);
                    removed = victim;
                end
            end
            ACT_UNLINK:
            begin
                if (list_len == 0 || !in_list[n])
                    st = ST_EMPTY;
                else
                begin
                    drop_node(n);
                    removed = n;
                end
            end
            ACT_ROTATE:
            begin
                // Old head becomes the tail, its successor the new head.
                if (list_len == 0)
                    st = ST_EMPTY;
                else
                begin
                    list_tail = list_head;
                    list_head = link_fwd[list_head];
                end
            end
            default: ;
        endcase
        return make_result(removed, st, list_len == 0, list_len);
    endfunction

    // Pick a node outside the list (any node when the list is full).
    function automatic logic [NODE_W-1:0] pick_free();
        logic [NODE_W-1:0] n;
        n = NODE_W'($urandom);
        if (list_len < POOL)
            while (in_list[n])
                n = n + 1'b1;
        return n;
    endfunction

    // Pick a member by walking a random distance from the head.
    function automatic logic [NODE_W-1:0] pick_member();
        int steps;
        int n;
        if (list_len == 0)
            return NODE_W'($urandom);
        steps = $urandom_range(list_len - 1);
        n = list_head;
        repeat (steps) n = link_fwd[n];
        return NODE_W'(n);
    endfunction

    // Offer one command transaction, hold it until accepted, then record its
    // expected result: the typed one for fixed table rows, else the prediction.
    task automatic send_cmd(input logic [ACTION_W-1:0] act, input logic [NODE_W-1:0] node,
                            input bit typed, input result_t want);
        result_t pred;
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {{(IN_TDATA_W-ACTION_W-NODE_W){1'b0}}, node, act};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        pred = apply_cmd(act, node);
        pending_results.push_back(typed ? want : pred);
    endtask

    task automatic issue(input logic [ACTION_W-1:0] act, input logic [NODE_W-1:0] node);
        send_cmd(act, node, 1'b0, '0);
    endtask

    // Lower valid and wait until every expected result has come back.
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    // Mostly well-formed commands on live nodes, with some raw noise.
    task automatic random_phase(input int n_items);
        int ins_pct;
        int r;
        logic [ACTION_W-1:0] act;
        logic [NODE_W-1:0] node;
        ins_pct = 45;
        for (int i = 0; i < n_items; i++)
        begin
            // Shift the insert bias now and then so the list grows and shrinks.
            if (i % 64 == 0)
                ins_pct = $urandom_range(30, 65);
            r = $urandom_range(99);
            if (r < 8)
            begin
                act  = ACTION_W'($urandom_range(7));
                node = NODE_W'($urandom);
            end
            else if (r < 8 + ins_pct)
            begin
                act  = $urandom_range(1) ? ACT_PUSH : ACT_APPEND;
                node = pick_free();
            end
            else
            begin
                r    = $urandom_range(99);
                node = NODE_W'($urandom);
                if (r < 35)
                begin
                    act  = ACT_UNLINK;
                    node = pick_member();
                end
                else if (r < 60)
                    act = ACT_POP_HEAD;
                else if (r < 85)
                    act = ACT_POP_TAIL;
                else
                    act = ACT_ROTATE;
            end
            issue(act, node);
        end
    endtask

    // Fill the whole pool, poke at it while full, then empty it again.
    task automatic fill_and_empty();
        repeat (POOL - list_len)
            issue($urandom_range(1) ? ACT_PUSH : ACT_APPEND, pick_free());
        repeat (3) issue(ACT_APPEND, NODE_W'($urandom));
        repeat (3) issue(ACT_PUSH, NODE_W'($urandom));
        repeat (5) issue(ACT_ROTATE, NODE_W'($urandom));
        repeat (4) issue(ACT_UNLINK, pick_member());
        repeat (4) issue(ACT_APPEND, pick_free());
        issue(ACT_PUSH, NODE_W'($urandom));
        while (list_len != 0)
        begin
            case ($urandom_range(2))
                0: issue(ACT_POP_HEAD, NODE_W'($urandom));
                1: issue(ACT_POP_TAIL, NODE_W'($urandom));
                default: issue(ACT_UNLINK, pick_member());
            endcase
        end
        issue(ACT_POP_TAIL, NODE_W'($urandom));
    endtask

    initial
    begin
        stim_row_t directed [$];
        foreach (link_fwd[i])
        begin
            link_fwd[i] = 0;
            link_bwd[i] = 0;
            in_list[i]  = 1'b0;
        end

        // Empty list: every removal and rotate reports empty; spare codes do nothing.
        directed.push_back('{ACT_POP_HEAD, 8'd0,   1'b1, make_result(0, ST_EMPTY, 1'b1, 0)});
        directed.push_back('{ACT_POP_TAIL, 8'd255, 1'b1, make_result(0, ST_EMPTY, 1'b1, 0)});
        directed.push_back('{ACT_UNLINK,   8'd0,   1'b1, make_result(0, ST_EMPTY, 1'b1, 0)});
        directed.push_back('{ACT_ROTATE,   8'd0,   1'b1, make_result(0, ST_EMPTY, 1'b1, 0)});
        directed.push_back('{ACT_SPARE_LO, 8'hAA,  1'b1, make_result(0, ST_OK, 1'b1, 0)});
        directed.push_back('{ACT_SPARE_HI, 8'h55,  1'b1, make_result(0, ST_OK, 1'b1, 0)});
        // Single node: insert, remove the last node, rotate with one node.
        directed.push_back('{ACT_APPEND,   8'd0,   1'b1, make_result(0, ST_OK, 1'b0, 1)});
        directed.push_back('{ACT_POP_HEAD, 8'd0,   1'b1, make_result(0, ST_OK, 1'b1, 0)});
        directed.push_back('{ACT_APPEND,   8'd255, 1'b1, make_result(0, ST_OK, 1'b0, 1)});
        directed.push_back('{ACT_ROTATE,   8'd0,   1'b1, make_result(0, ST_OK, 1'b0, 1)});
        directed.push_back('{ACT_POP_TAIL, 8'd0,   1'b1, make_result(255, ST_OK, 1'b1, 0)});
        directed.push_back('{ACT_PUSH,     8'd255, 1'b1, make_result(0, ST_OK, 1'b0, 1)});
        directed.push_back('{ACT_APPEND,   8'd0,   1'b1, make_result(0, ST_OK, 1'b0, 2)});
        // Inserting a node that is already linked is refused.
        directed.push_back('{ACT_PUSH,     8'd0,   1'b1, make_result(0, ST_FULL, 1'b0, 2)});
        directed.push_back('{ACT_APPEND,   8'd255, 1'b1, make_result(0, ST_FULL, 1'b0, 2)});
        directed.push_back('{ACT_PUSH,     8'd128, 1'b0, '0});
        directed.push_back('{ACT_APPEND,   8'd1,   1'b0, '0});
        directed.push_back('{ACT_ROTATE,   8'd0,   1'b0, '0});
        // Unlinking a node that is not in the list reports empty.
        directed.push_back('{ACT_UNLINK,   8'd77,  1'b1, make_result(0, ST_EMPTY, 1'b0, 4)});
        directed.push_back('{ACT_UNLINK,   8'd0,   1'b0, '0});
        directed.push_back('{ACT_ROTATE,   8'd0,   1'b0, '0});
        directed.push_back('{ACT_SPARE_HI, 8'hFF,  1'b0, '0});
        directed.push_back('{ACT_POP_HEAD, 8'd0,   1'b0, '0});
        directed.push_back('{ACT_POP_TAIL, 8'd0,   1'b0, '0});
        directed.push_back('{ACT_UNLINK,   8'd1,   1'b0, '0});

        // Single reset at the start; the clearing pass is covered by waiting on tready.
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed[i])
            send_cmd(directed[i].act, directed[i].node, directed[i].typed, directed[i].want);
        drain_results();

        // No idling; hold the receiver off while commands keep coming so the
        // output register fills and the input stalls.
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_reqs++;
        repeat (30) issue($urandom_range(1) ? ACT_PUSH : ACT_APPEND, pick_free());
        random_phase(400);
        // Pause the sender until every result is back.
        drain_results();

        send_idle_pct  = 49;
        recv_stall_pct = 0;
        random_phase(400);
        drain_results();

        send_idle_pct  = 0;
        recv_stall_pct = 49;
        fill_and_empty();
        random_phase(400);
        drain_results();

        send_idle_pct  = 10;
        recv_stall_pct = 10;
        random_phase(400);
        drain_results();

        // Allow for stray results after the last expected one.
        repeat (TAIL_CYCLES) @(posedge clk);
        if (n_bad == 0 && pending_results.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
